FILE: rtl/bma_pkg.sv
package bma_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 7;

    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd10;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic produce;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/bma_if.sv
interface bma_sample_if #(
    parameter int WIDTH = bma_pkg::SAMPLE_BITS
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface bma_average_if #(
    parameter int WIDTH = bma_pkg::SAMPLE_BITS
);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

FILE: rtl/boxcar_moving_average.sv
// Results: a request that completes a window has its average loaded into the output register
//   after the update, divide and done states; earlier requests give no result.
// Flow: a new request is taken only once the previous one is finished, in the idle state;
//   the one-bit-per-cycle restoring divider works over the 22-bit sum magnitude.
// Reset: synchronous, active low; window length returns to 10, the fill restarts, and the
//   sample store is not cleared. A configuration write also restarts the fill.
module boxcar_moving_average #(
    parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0] i_cfg_data,
    bma_sample_if.sink                i_sample_if,
    bma_average_if.source             o_average_if
);

    bma_pkg::t_cmd  cmd;
    bma_pkg::t_stat stat;
    logic           in_ready;

    bma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_if.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bma_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (i_sample_if.sample),
        .o_average   (o_average_if.average),
        .o_out_valid (o_average_if.valid),
        .i_out_ready (o_average_if.ready),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    assign i_sample_if.ready = in_ready;

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.update, cmd.div_step, cmd.load_out}))
        else $error("more than one datapath command at once");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample_if.valid && in_ready) |=> !in_ready)
        else $error("request taken while previous one in progress");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_average_if.valid)
        else $error("loaded average not presented");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_average_if.valid || o_average_if.ready))
        else $error("average overwritten before taken");

endmodule

FILE: rtl/bma_ram.sv
module bma_ram #(
    parameter int WIDTH = bma_pkg::SAMPLE_BITS,
    parameter int DEPTH = bma_pkg::MAX_WINDOW
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bma_ctrl.sv
module bma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bma_pkg::t_stat i_stat,
    output bma_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.produce ? S_DIVIDE : S_IDLE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.load_out = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/bma_dp.sv
module bma_dp #(
    parameter int MAX_WINDOW  = bma_pkg::MAX_WINDOW,
    parameter int SAMPLE_BITS = bma_pkg::SAMPLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    output logic [SAMPLE_BITS-1:0]      o_average,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  bma_pkg::t_cmd               i_cmd,
    output bma_pkg::t_stat              o_stat
);

    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    logic [bma_pkg::CFG_W-1:0] r_window_len;
    logic [SUM_W-1:0]          r_sum;
    logic [ADDR_W-1:0]         r_slot;
    logic [LEN_W-1:0]          r_fill;
    logic [SAMPLE_BITS-1:0]    r_sample;
    logic [LEN_W-1:0]          r_rem;
    logic [MAG_W-1:0]          r_quo;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;
    logic [SAMPLE_BITS-1:0]    r_avg;
    logic                      r_out_valid;

    logic [LEN_W-1:0]       len;
    logic [ADDR_W-1:0]      slot_eff;
    logic [LEN_W-1:0]       slot_inc;
    logic [ADDR_W-1:0]      n_slot;
    logic                   full;
    logic [LEN_W-1:0]       fill_inc;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_W-1:0]       old_ext;
    logic [SUM_W-1:0]       smp_ext;
    logic [SUM_W-1:0]       n_sum;
    logic [SUM_W-1:0]       sum_abs;
    logic [LEN_W:0]         rem_sh;
    logic                   rem_ge;
    logic [LEN_W:0]         rem_sub;
    logic [SAMPLE_BITS-1:0] quo_lo;

    always_comb begin
        if (r_window_len == '0) begin
            len = LEN_W'(1);
        end else if (32'(r_window_len) > 32'(MAX_WINDOW)) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(r_window_len);
        end
    end

    always_comb begin
        slot_eff = (32'(r_slot) >= 32'(len)) ? '0 : r_slot;
        slot_inc = LEN_W'(slot_eff) + LEN_W'(1);
        n_slot   = (slot_inc >= len) ? '0 : ADDR_W'(slot_inc);
        full     = (r_fill >= len);
        fill_inc = r_fill + LEN_W'(1);
        old_ext  = {{(SUM_W - SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
        smp_ext  = {{(SUM_W - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
        n_sum    = r_sum - (full ? old_ext : '0) + smp_ext;
        sum_abs  = n_sum[SUM_W-1] ? (~n_sum + SUM_W'(1)) : n_sum;
        rem_sh   = {r_rem, r_quo[MAG_W-1]};
        rem_ge   = (rem_sh >= {1'b0, len});
        rem_sub  = rem_sh - {1'b0, len};
        quo_lo   = r_quo[SAMPLE_BITS-1:0];
    end

    bma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (slot_eff),
        .i_wdata (r_sample),
        .i_re    (i_cmd.accept),
        .i_raddr (slot_eff),
        .o_rdata (old_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= bma_pkg::WINDOW_LEN_RESET;
            r_sum        <= '0;
            r_slot       <= '0;
            r_fill       <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window_len <= i_cfg_data;
                r_sum        <= '0;
                r_slot       <= '0;
                r_fill       <= '0;
            end else if (i_cmd.update) begin
                r_sum  <= n_sum;
                r_slot <= n_slot;
                if (!full) begin
                    r_fill <= fill_inc;
                end
            end
            if (i_cmd.update) begin
                r_cnt <= CNT_W'(MAG_W);
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.update) begin
            r_rem <= '0;
            r_quo <= sum_abs[MAG_W-1:0];
            r_neg <= n_sum[SUM_W-1];
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], rem_ge};
        end
        if (i_cmd.load_out) begin
            r_avg <= r_neg ? (~quo_lo + SAMPLE_BITS'(1)) : quo_lo;
        end
    end

    always_comb begin
        o_stat.produce  = full || (fill_inc == len);
        o_stat.div_done = (r_cnt == CNT_W'(1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_average   = r_avg;
    assign o_out_valid = r_out_valid;

endmodule
